// ===== design/arpc_pkg.sv =====
// Shared types and constants of the ARP resolver cache.
package arpc_pkg;

    localparam int CACHE_ENTRIES_DEF   = 16;
    localparam int PENDING_ENTRIES_DEF = 8;
    localparam int TAG_BITS_DEF        = 16;
    localparam int FIFO_DEPTH          = 2;

    localparam logic [1:0] ACT_SEND = 2'd0;
    localparam logic [1:0] ACT_RECV = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam logic [1:0] KIND_IPV4    = 2'd0;
    localparam logic [1:0] KIND_ARP_REQ = 2'd1;
    localparam logic [1:0] KIND_ARP_REP = 2'd2;
    localparam logic [1:0] KIND_DELIVER = 2'd3;

    localparam logic [1:0] REG_OWN_MAC   = 2'd0;
    localparam logic [1:0] REG_OWN_IP    = 2'd1;
    localparam logic [1:0] REG_PEND_WIN  = 2'd2;
    localparam logic [1:0] REG_CACHE_TMO = 2'd3;

    localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;
    localparam logic [23:0] MAX24     = 24'hFF_FFFF;

    // Classified work handed from the front to the back.
    localparam logic [1:0] OP_SEND  = 2'd0;
    localparam logic [1:0] OP_ARP   = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_DELIV = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] next_hop_ip;
        logic [15:0] payload_tag;
        logic [47:0] frame_dst_mac;
        logic        frame_is_ipv4;
        logic        parse_ok;
        logic        arp_is_request;
        logic [31:0] arp_sender_ip;
        logic [47:0] arp_sender_mac;
        logic [31:0] arp_target_ip;
        logic [15:0] elapsed_ms;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] dst_mac;
        logic [31:0] target_ip;
        logic [15:0] out_tag;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [15:0] tag;
        logic        want_reply;
    } t_job;

endpackage

// ===== design/arp_resolver_cache.sv =====
// Top level of the ARP resolver cache.
// A request is taken when i_start is high and o_busy is low; results appear
// for one cycle each with o_valid and cannot be held off. A send or an ARP
// message walks the cache table and then the pending table before it acts,
// and may give two results; a tick walks the cache table, a delivery goes
// straight out, and a request dropped when it is classified gives no result.
// The back end walks the cache and pending tables one entry per cycle.
module arp_resolver_cache import arpc_pkg::*; #(
    parameter int CACHE_ENTRIES   = CACHE_ENTRIES_DEF,
    parameter int PENDING_ENTRIES = PENDING_ENTRIES_DEF,
    parameter int TAG_BITS        = TAG_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_req        i_req,
    output logic        o_valid,
    output t_res        o_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);
    logic [47:0] r_own_mac;
    logic [31:0] r_own_ip;
    logic [23:0] r_pend_win, r_cache_tmo;
    logic        w_full, w_empty, w_pop, w_back_busy;
    t_job        w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
            r_own_ip <= '0;
            r_pend_win <= 24'd5000;
            r_cache_tmo <= 24'd30000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OWN_MAC:   r_own_mac <= i_cfg_data;
                REG_OWN_IP:    r_own_ip <= i_cfg_data[31:0];
                REG_PEND_WIN:  r_pend_win <= i_cfg_data[23:0];
                REG_CACHE_TMO: r_cache_tmo <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Holding off new requests while the back end works keeps the order of
    // table updates the same as the order of requests.
    assign o_busy = w_full || !w_empty || w_back_busy;

    arpc_front u_front (
        .i_clk, .i_rst_n,
        .i_take(i_start && !o_busy), .i_req,
        .i_own_mac(r_own_mac), .i_own_ip(r_own_ip),
        .i_pop(w_pop), .o_full(w_full), .o_empty(w_empty), .o_job(w_job)
    );

    arpc_back #(
        .CACHE_ENTRIES(CACHE_ENTRIES), .PENDING_ENTRIES(PENDING_ENTRIES),
        .TAG_BITS(TAG_BITS)
    ) u_back (
        .i_clk, .i_rst_n, .i_empty(w_empty), .i_job(w_job),
        .i_pend_win(r_pend_win), .i_cache_tmo(r_cache_tmo),
        .o_pop(w_pop), .o_busy(w_back_busy), .o_res_valid(o_valid), .o_res
    );

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty) else $error("pop from empty queue");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> !w_full) else $error("request into full queue");
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.last) |=> (o_valid && o_res.last))
        else $error("second result missing");
`endif
endmodule

// ===== design/arpc_front.sv =====
// Front end: classifies requests and queues jobs for the back end.
module arpc_front import arpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  t_req        i_req,
    input  logic [47:0] i_own_mac,
    input  logic [31:0] i_own_ip,
    input  logic        i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_job        o_job
);
    t_job       r_q [FIFO_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job       n_job;
    logic       n_keep;

    always_comb begin
        n_job = '0;
        n_keep = 1'b0;
        n_job.tag = i_req.payload_tag;
        case (i_req.action)
            ACT_SEND: begin
                n_keep = 1'b1;
                n_job.op = OP_SEND;
                n_job.ip = i_req.next_hop_ip;
            end
            ACT_RECV: begin
                if ((i_req.frame_dst_mac == i_own_mac || i_req.frame_dst_mac == BCAST_MAC)
                        && i_req.parse_ok) begin
                    n_keep = 1'b1;
                    n_job.op = i_req.frame_is_ipv4 ? OP_DELIV : OP_ARP;
                    n_job.ip = i_req.arp_sender_ip;
                    n_job.mac = i_req.arp_sender_mac;
                    n_job.want_reply = i_req.arp_is_request
                                       && (i_req.arp_target_ip == i_own_ip);
                end
            end
            ACT_TICK: begin
                n_keep = 1'b1;
                n_job.op = OP_TICK;
                n_job.tag = i_req.elapsed_ms;
            end
            default: n_keep = 1'b0;
        endcase
    end

    wire w_push = i_take && n_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
        if (w_push) r_q[r_wp] <= n_job;
    end

    assign o_full  = (r_cnt == 2'(FIFO_DEPTH));
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_q[r_rp];
endmodule

// ===== design/arpc_back.sv =====
// Back end: walks the cache and pending tables one entry per cycle.
module arpc_back import arpc_pkg::*; #(
    parameter int CACHE_ENTRIES   = CACHE_ENTRIES_DEF,
    parameter int PENDING_ENTRIES = PENDING_ENTRIES_DEF,
    parameter int TAG_BITS        = TAG_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_job,
    input  logic [23:0] i_pend_win,
    input  logic [23:0] i_cache_tmo,
    output logic        o_pop,
    output logic        o_busy,
    output logic        o_res_valid,
    output t_res        o_res
);
    localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int NW = ((CACHE_ENTRIES > PENDING_ENTRIES) ? $clog2(CACHE_ENTRIES + 1)
                                                          : $clog2(PENDING_ENTRIES + 1));

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CSCAN = 3'd1;
    localparam logic [2:0] S_PSCAN = 3'd2;
    localparam logic [2:0] S_ACT   = 3'd3;
    localparam logic [2:0] S_OUT2  = 3'd4;
    localparam logic [2:0] S_TICK  = 3'd5;

    logic [CACHE_ENTRIES-1:0]   r_cv;
    logic [31:0]                r_cip  [CACHE_ENTRIES];
    logic [47:0]                r_cmac [CACHE_ENTRIES];
    logic [23:0]                r_cage [CACHE_ENTRIES];
    logic [PENDING_ENTRIES-1:0] r_pv;
    logic [31:0]                r_pip  [PENDING_ENTRIES];
    logic [TAG_BITS-1:0]        r_ptag [PENDING_ENTRIES];
    logic [23:0]                r_ptimer;

    logic [2:0]    r_st;
    t_job          r_job;
    logic [NW-1:0] r_idx;
    logic          r_chit, r_cfree_ok, r_phit, r_pfree_ok;
    logic [CW-1:0] r_chit_i, r_cfree;
    logic [PW-1:0] r_phit_i, r_pfree;
    logic          r_ov;
    t_res          r_res;

    wire [CW-1:0] w_ci = r_idx[CW-1:0];
    wire [PW-1:0] w_pi = r_idx[PW-1:0];
    wire [TAG_BITS-1:0] w_tag = r_job.tag[TAG_BITS-1:0];
    wire [24:0] w_psum = {1'b0, r_ptimer} + {9'd0, r_job.tag};
    wire [23:0] w_pnew = w_psum[24] ? MAX24 : w_psum[23:0];
    wire [24:0] w_csum = {1'b0, r_cage[w_ci]} + {9'd0, r_job.tag};
    wire [23:0] w_cnew = w_csum[24] ? MAX24 : w_csum[23:0];

    function automatic t_res mk(logic [1:0] k, logic [47:0] m, logic [31:0] ip,
                                logic [15:0] t, logic l);
        t_res r;
        r.kind = k; r.dst_mac = m; r.target_ip = ip; r.out_tag = t; r.last = l;
        return r;
    endfunction

    assign o_busy = (r_st != S_IDLE);
    assign o_pop  = (r_st == S_IDLE) && !i_empty;
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cv <= '0;
            r_pv <= '0;
            r_ptimer <= '0;
            r_ov <= 1'b0;
        end else begin
            r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job <= i_job;
                        r_idx <= '0;
                        r_chit <= 1'b0; r_cfree_ok <= 1'b0;
                        r_phit <= 1'b0; r_pfree_ok <= 1'b0;
                        case (i_job.op)
                            OP_DELIV: begin
                                r_ov <= 1'b1;
                                r_res <= mk(KIND_DELIVER, '0, '0,
                                            16'(i_job.tag[TAG_BITS-1:0]), 1'b1);
                            end
                            OP_TICK: r_st <= S_TICK;
                            default: r_st <= S_CSCAN;
                        endcase
                    end
                end
                S_CSCAN: begin
                    if (r_cv[w_ci] && r_cip[w_ci] == r_job.ip && !r_chit) begin
                        r_chit <= 1'b1; r_chit_i <= w_ci;
                    end
                    if (!r_cv[w_ci] && !r_cfree_ok) begin
                        r_cfree_ok <= 1'b1; r_cfree <= w_ci;
                    end
                    if (r_idx == NW'(CACHE_ENTRIES - 1)) begin
                        r_idx <= '0; r_st <= S_PSCAN;
                    end else r_idx <= r_idx + 1'b1;
                end
                S_PSCAN: begin
                    if (r_pv[w_pi] && r_pip[w_pi] == r_job.ip && !r_phit) begin
                        r_phit <= 1'b1; r_phit_i <= w_pi;
                    end
                    if (!r_pv[w_pi] && !r_pfree_ok) begin
                        r_pfree_ok <= 1'b1; r_pfree <= w_pi;
                    end
                    if (r_idx == NW'(PENDING_ENTRIES - 1)) r_st <= S_ACT;
                    else r_idx <= r_idx + 1'b1;
                end
                S_ACT: begin
                    r_st <= S_IDLE;
                    if (r_job.op == OP_SEND) begin
                        if (r_chit) begin
                            r_ov <= 1'b1;
                            r_res <= mk(KIND_IPV4, r_cmac[r_chit_i], '0, 16'(w_tag), 1'b1);
                        end else if (!r_phit) begin
                            r_ov <= 1'b1;
                            r_res <= mk(KIND_ARP_REQ, BCAST_MAC, r_job.ip, '0, 1'b1);
                            if (r_pfree_ok) begin
                                r_pv[r_pfree] <= 1'b1;
                                r_pip[r_pfree] <= r_job.ip;
                                r_ptag[r_pfree] <= w_tag;
                            end
                        end
                    end else begin
                        if (!r_chit) begin
                            if (r_cfree_ok) begin
                                r_cv[r_cfree] <= 1'b1;
                                r_cip[r_cfree] <= r_job.ip;
                                r_cmac[r_cfree] <= r_job.mac;
                                r_cage[r_cfree] <= '0;
                            end
                            if (r_phit) begin
                                r_pv[r_phit_i] <= 1'b0;
                                r_ov <= 1'b1;
                                r_res <= mk(KIND_IPV4, r_job.mac, '0,
                                            16'(r_ptag[r_phit_i]), !r_job.want_reply);
                                if (r_job.want_reply) r_st <= S_OUT2;
                            end
                        end
                        if (r_job.want_reply && (r_chit || !r_phit)) begin
                            r_ov <= 1'b1;
                            r_res <= mk(KIND_ARP_REP, r_job.mac, r_job.ip, '0, 1'b1);
                        end
                    end
                end
                S_OUT2: begin
                    r_ov <= 1'b1;
                    r_res <= mk(KIND_ARP_REP, r_job.mac, r_job.ip, '0, 1'b1);
                    r_st <= S_IDLE;
                end
                S_TICK: begin
                    if (r_idx == '0) begin
                        if (w_pnew > i_pend_win) begin
                            r_ptimer <= '0;
                            r_pv <= '0;
                        end else r_ptimer <= w_pnew;
                    end
                    if (r_cv[w_ci]) begin
                        r_cage[w_ci] <= w_cnew;
                        if (w_cnew > i_cache_tmo) r_cv[w_ci] <= 1'b0;
                    end
                    if (r_idx == NW'(CACHE_ENTRIES - 1)) r_st <= S_IDLE;
                    else r_idx <= r_idx + 1'b1;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_res_valid = r_ov;
endmodule
